// ----- rtl/core/gscc_pkg.sv -----
// Shared types, field layout and fixed-point helpers for the gated causal convolution unit.
package gscc_pkg;

    localparam int DataW = 16;
    localparam int FracW = 12;
    localparam int LayerW = 4;
    localparam int ChanW = 10;
    localparam int TapW = 2;
    localparam int ProdW = 2 * DataW;
    localparam int RsW = 40;
    localparam int QW = RsW - FracW + 1;

    localparam int CHANNELS_DEF = 1024;
    localparam int TAPS_DEF = 3;
    localparam int LAYERS_DEF = 16;

    // Slave-side tdata layout, lowest bit first.
    localparam int S_LAYER_LSB = 0;
    localparam int S_CHAN_LSB = S_LAYER_LSB + LayerW;
    localparam int S_TAP_LSB = S_CHAN_LSB + ChanW;
    localparam int S_WEIGHT_LSB = S_TAP_LSB + TapW;
    localparam int S_B_LSB = S_WEIGHT_LSB + DataW;
    localparam int S_C_LSB = S_B_LSB + DataW;
    localparam int S_X_LSB = S_C_LSB + DataW;
    localparam int S_TDATA_W = ((S_X_LSB + DataW + 7) / 8) * 8;

    // Slave-side tuser layout.
    localparam int S_FUNC_BIT = 0;
    localparam int S_FIRST_BIT = 1;
    localparam int S_TUSER_W = 2;

    // Master-side tdata layout.
    localparam int M_Y_LSB = 0;
    localparam int M_LAYER_LSB = M_Y_LSB + DataW;
    localparam int M_CHAN_LSB = M_LAYER_LSB + LayerW;
    localparam int M_USED_W = M_CHAN_LSB + ChanW;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    localparam logic [RsW:0] RND_HALF = (RsW + 1)'(2 ** (FracW - 1));
    localparam logic signed [QW-1:0] QMAX = QW'(2 ** (DataW - 1) - 1);
    localparam logic signed [QW-1:0] QMIN = -QMAX - QW'(1);

    typedef struct packed {
        logic latch;
        logic rd;
        logic mul_bx;
        logic bx;
        logic mul_tap;
        logic acc;
        logic conv;
        logic hist_wr;
        logic mul_gate;
        logic load_out;
        logic w_wr;
        logic clr_wr;
    } cmd_t;

    typedef struct packed {
        logic is_sample;
        logic in_range;
        logic tap_ok;
        logic k_last;
        logic clr_last;
        logic out_busy;
    } status_t;

    // Q16.24 to Q4.12 with round half up and saturation.
    function automatic logic signed [DataW-1:0] round_sat(input logic signed [RsW-1:0] v);
        logic [RsW:0] t;
        logic signed [QW-1:0] q;
        logic signed [DataW-1:0] r;
        t = {v[RsW-1], v} + RND_HALF;
        q = $signed(t[RsW:FracW]);
        if (q > QMAX) begin
            r = QMAX[DataW-1:0];
        end else if (q < QMIN) begin
            r = QMIN[DataW-1:0];
        end else begin
            r = q[DataW-1:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/gscc_ctrl.sv -----
// Sequencing state machine for the gated causal convolution unit.
module gscc_ctrl
    import gscc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_DECODE = 4'd2;
    localparam logic [3:0] ST_BX = 4'd3;
    localparam logic [3:0] ST_MUL = 4'd4;
    localparam logic [3:0] ST_ACC = 4'd5;
    localparam logic [3:0] ST_CONV = 4'd6;
    localparam logic [3:0] ST_GATE = 4'd7;
    localparam logic [3:0] ST_OUT = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!status.in_range) begin
                    state_next = ST_IDLE;
                end else if (!status.is_sample) begin
                    cmd.w_wr = status.tap_ok;
                    state_next = ST_IDLE;
                end else begin
                    cmd.rd = 1'b1;
                    cmd.mul_bx = 1'b1;
                    state_next = ST_BX;
                end
            end
            ST_BX: begin
                cmd.bx = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_tap = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc = 1'b1;
                state_next = status.k_last ? ST_CONV : ST_MUL;
            end
            ST_CONV: begin
                cmd.conv = 1'b1;
                cmd.hist_wr = 1'b1;
                state_next = ST_GATE;
            end
            ST_GATE: begin
                cmd.mul_gate = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/gscc_datapath.sv -----
// Datapath: request registers, history and weight memories, shared multiplier and output register.
module gscc_datapath
    import gscc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int TAPS = TAPS_DEF,
    parameter int LAYERS = LAYERS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output status_t              status,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int Rows = LAYERS * CHANNELS;
    localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;
    localparam int HistW = (TAPS - 1) * DataW;
    localparam int KW = $clog2(TAPS);
    localparam int AccW = ProdW + $clog2(TAPS);

    logic                     is_sample_reg;
    logic                     first_reg;
    logic                     in_range_reg;
    logic                     tap_ok_reg;
    logic [TapW-1:0]          tap_reg;
    logic [DataW-1:0]         weight_reg;
    logic signed [DataW-1:0]  b_reg;
    logic signed [DataW-1:0]  c_reg;
    logic signed [DataW-1:0]  x_reg;
    logic [LayerW-1:0]        layer_reg;
    logic [ChanW-1:0]         chan_reg;
    logic [RowW-1:0]          row_reg;

    logic [HistW-1:0]         hist_mem [Rows];
    logic [HistW-1:0]         hist_rd_reg;
    logic [RowW-1:0]          hist_waddr;
    logic [HistW-1:0]         hist_wdata;
    logic [HistW-1:0]         hist_new;
    logic [RowW-1:0]          clr_cnt_reg;

    logic signed [DataW-1:0]  w_rd [TAPS];
    logic signed [DataW-1:0]  win [TAPS];

    logic signed [DataW-1:0]  mul_a;
    logic signed [DataW-1:0]  mul_b;
    logic signed [ProdW-1:0]  prod_reg;
    logic signed [DataW-1:0]  bx_reg;
    logic signed [AccW-1:0]   acc_reg;
    logic [KW-1:0]            k_reg;
    logic signed [DataW-1:0]  conv_reg;

    logic                     out_valid_reg;
    logic signed [DataW-1:0]  y_reg;
    logic [LayerW-1:0]        out_layer_reg;
    logic [ChanW-1:0]         out_chan_reg;

    // Request capture and address formation.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            is_sample_reg <= (s_tuser[S_FUNC_BIT] == FUNC_SAMPLE);
            first_reg <= s_tuser[S_FIRST_BIT];
            in_range_reg <= (32'(s_tdata[S_LAYER_LSB +: LayerW]) < LAYERS) &&
                            (32'(s_tdata[S_CHAN_LSB +: ChanW]) < CHANNELS);
            tap_ok_reg <= (32'(s_tdata[S_TAP_LSB +: TapW]) < TAPS);
            tap_reg <= s_tdata[S_TAP_LSB +: TapW];
            weight_reg <= s_tdata[S_WEIGHT_LSB +: DataW];
            b_reg <= s_tdata[S_B_LSB +: DataW];
            c_reg <= s_tdata[S_C_LSB +: DataW];
            x_reg <= s_tdata[S_X_LSB +: DataW];
            layer_reg <= s_tdata[S_LAYER_LSB +: LayerW];
            chan_reg <= s_tdata[S_CHAN_LSB +: ChanW];
            row_reg <= RowW'(32'(s_tdata[S_LAYER_LSB +: LayerW]) * CHANNELS +
                             32'(s_tdata[S_CHAN_LSB +: ChanW]));
        end
    end

    // Tap weight memories, one per tap, one row per layer and channel.
    for (genvar t = 0; t < TAPS; t++) begin : g_tap
        logic [DataW-1:0] w_mem [Rows];
        logic [DataW-1:0] w_rd_reg;

        always_ff @(posedge aclk) begin
            if (cmd.w_wr && (32'(tap_reg) == t)) begin
                w_mem[row_reg] <= weight_reg;
            end
            if (cmd.rd) begin
                w_rd_reg <= w_mem[row_reg];
            end
        end

        assign w_rd[t] = w_rd_reg;
    end

    // The convolution window: earlier history (or zeros at a sequence start) and the new bx.
    always_comb begin
        for (int k = 0; k < TAPS - 1; k++) begin
            win[k] = first_reg ? '0 : hist_rd_reg[k * DataW +: DataW];
        end
        win[TAPS-1] = bx_reg;
        for (int k = 0; k < TAPS - 1; k++) begin
            hist_new[k * DataW +: DataW] = win[k + 1];
        end
    end

    assign hist_waddr = cmd.clr_wr ? clr_cnt_reg : row_reg;
    assign hist_wdata = cmd.clr_wr ? '0 : hist_new;

    always_ff @(posedge aclk) begin
        if (cmd.clr_wr || cmd.hist_wr) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (cmd.rd) begin
            hist_rd_reg <= hist_mem[row_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_cnt_reg <= clr_cnt_reg + RowW'(1);
        end
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = b_reg;
        mul_b = x_reg;
        if (cmd.mul_tap) begin
            mul_a = win[k_reg];
            mul_b = w_rd[k_reg];
        end else if (cmd.mul_gate) begin
            mul_a = c_reg;
            mul_b = conv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_bx || cmd.mul_tap || cmd.mul_gate) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.bx) begin
            bx_reg <= round_sat(RsW'(prod_reg));
        end
        if (cmd.bx) begin
            acc_reg <= '0;
        end else if (cmd.acc) begin
            acc_reg <= acc_reg + AccW'(prod_reg);
        end
        if (cmd.conv) begin
            conv_reg <= round_sat(RsW'(acc_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else if (cmd.bx) begin
            k_reg <= '0;
        end else if (cmd.acc) begin
            k_reg <= k_reg + KW'(1);
        end
    end

    // Output register, free to take a new result once the current one is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            y_reg <= round_sat(RsW'(prod_reg));
            out_layer_reg <= layer_reg;
            out_chan_reg <= chan_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = M_TDATA_W'({out_chan_reg, out_layer_reg, y_reg});

    assign status.is_sample = is_sample_reg;
    assign status.in_range = in_range_reg;
    assign status.tap_ok = tap_ok_reg;
    assign status.k_last = (k_reg == KW'(TAPS - 1));
    assign status.clr_last = (clr_cnt_reg == RowW'(Rows - 1));
    assign status.out_busy = out_valid_reg && !m_tready;

endmodule

// ----- rtl/core/gated_short_causal_conv_unit.sv -----
// Top level of the gated short causal convolution unit.
//
// Requests arrive on the s_ stream: a load request (tuser func 0) writes one tap weight of
// one layer and channel and returns nothing; a sample request (func 1) forms bx = b*x, runs
// the TAPS-tap causal convolution over the channel's history and returns y = c*conv on the
// m_ stream with its layer and channel. Requests with an out-of-range layer or channel, and
// loads with an out-of-range tap, are dropped. All data is signed Q4.12, rounded half up
// and saturated.
// One request is processed at a time; a load is written in the decode step. A sample runs
// through the single shared 16x16 multiplier, which handles b*x, then each tap in turn (a
// multiply and an accumulate step) and the final gate; the result then waits to be loaded
// into the output register, which it enters once that register is free.
// After reset the history memory is swept to zero, one layer and channel row per cycle,
// all LAYERS*CHANNELS rows (16384 by default); s_tready stays low until the sweep ends.
// The result sits in an output register; the next request is taken while it waits, and a
// new result waits inside the unit while m_tready is low.
module gated_short_causal_conv_unit
    import gscc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int TAPS = TAPS_DEF,
    parameter int LAYERS = LAYERS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: layer, channel, tap, weight, gate_b, gate_c, x_value.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: func, first_of_sequence.
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: y, out_layer, out_channel, then zero padding.
    output logic [M_TDATA_W-1:0] m_tdata
);

    cmd_t    cmd;
    status_t status;

    gscc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gscc_datapath #(
        .CHANNELS (CHANNELS),
        .TAPS     (TAPS),
        .LAYERS   (LAYERS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule
